/* sv/chisq_pkg.sv */
// chisq_pkg: shared widths, control structs and constants of the chi-square block
// no dependencies; compiled first

package chisq_pkg;

  // field widths fixed by the interface
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned CHI_W    = 34;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned SUMSQ_W  = 33;
  localparam int unsigned SQR_W    = 34;
  localparam int unsigned FRAC_W   = 8;

  // block length limits and reset value
  localparam logic [LEN_W-1:0] LEN_RESET = 17'd1024;
  localparam logic [LEN_W-1:0] LEN_MAX   = 17'd65536;
  localparam logic [LEN_W-1:0] LEN_MIN   = 17'd1;

  // sequencer to histogram
  typedef struct packed {
    logic lookup;
    logic update;
    logic clear;
  } hist_ctrl_t;

  // histogram to sequencer
  typedef struct packed {
    logic clear_last;
  } hist_stat_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* sv/chisq_in_if.sv */
// chisq_in_if: sample request channel, valid/ready with one sample field
// depends on chisq_pkg

interface chisq_in_if import chisq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* sv/chisq_out_if.sv */
// chisq_out_if: result request channel, valid/ready with statistic and block index
// depends on chisq_pkg

interface chisq_out_if import chisq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CHI_W-1:0] chi_square;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output chi_square, output block_index, input ready);
  modport sink   (input valid, input chi_square, input block_index, output ready);
endinterface

/* sv/chisq_hist.sv */
// chisq_hist: bin index, histogram memory with read-modify-write and clearing sweep
// depends on chisq_pkg

module chisq_hist import chisq_pkg::*; #(
  parameter int unsigned BINS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hist_ctrl_t          ctrl_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output hist_stat_t          stat_o,
  output logic [LEN_W:0]      sq_incr_o
);

  localparam int unsigned BIN_W = $clog2(BINS);
  localparam int unsigned BCW   = $clog2(BINS + 1);
  localparam int unsigned PRD_W = SAMPLE_W + BCW;
  localparam logic [BCW-1:0]   BINS_V   = BCW'(BINS);
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BINS - 1);

  logic [LEN_W-1:0] mem [BINS];
  logic [LEN_W-1:0] rdata_q;
  logic [BIN_W-1:0] bin_q;
  logic [BIN_W-1:0] clr_addr_q, clr_addr_d;
  logic [PRD_W-1:0] prod;
  logic [BIN_W-1:0] bin_d;
  logic             we;
  logic [BIN_W-1:0] waddr;
  logic [LEN_W-1:0] wdata;

  // bin = (sample * BINS) >> 16
  assign prod  = PRD_W'(sample_i) * PRD_W'(BINS_V);
  assign bin_d = prod[SAMPLE_W +: BIN_W];

  // write port: clearing sweep or count increment
  assign we    = ctrl_i.clear | ctrl_i.update;
  assign waddr = ctrl_i.clear ? clr_addr_q : bin_q;
  assign wdata = ctrl_i.clear ? '0 : rdata_q + LEN_W'(1);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl_i.lookup) begin
      rdata_q <= mem[bin_d];
      bin_q   <= bin_d;
    end
  end

  // clearing address walks the memory once
  always_comb begin
    clr_addr_d = clr_addr_q;
    if (ctrl_i.clear) begin
      clr_addr_d = (clr_addr_q == BIN_LAST) ? '0 : clr_addr_q + BIN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else begin
      clr_addr_q <= clr_addr_d;
    end
  end

  assign stat_o.clear_last = ctrl_i.clear && (clr_addr_q == BIN_LAST);

  // a hit on a bin holding c adds 2c+1 to the sum of squares
  assign sq_incr_o = {rdata_q, 1'b1};

endmodule

/* sv/chisq_div.sv */
// chisq_div: restoring divider, one quotient bit per cycle
// depends on chisq_pkg

module chisq_div import chisq_pkg::*; #(
  parameter int unsigned DW = 49
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW-1:0]    dividend_i,
  input  logic [LEN_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [DW-1:0]    quotient_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

  logic [DW-1:0]    quo_q;
  logic [LEN_W-1:0] rem_q;
  logic [LEN_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   rem_sub;
  logic             ge;

  // one shift-and-subtract step
  assign rem_sh  = {rem_q, quo_q[DW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
    end
  end

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

/* sv/chi_square_uniformity_test.sv */
// Pearson chi-square uniformity test over blocks of 16-bit samples. Each sample is first
// looked up, reading its bin count from the histogram memory; then the incremented count
// is written back and 2c+1 added to the sum of squares, and no new sample is taken until
// that update is done. When a block completes, the statistic is built by two registered
// multiplies, a subtract and a restoring divider giving one quotient bit a cycle; the
// result register is then loaded and a clearing pass runs over the histogram, one bin a
// cycle, during which no sample is taken. The same clearing pass runs after reset. A
// finished result waits in an output register, so the next block may start while it is
// still unclaimed; a further block end stalls only until that result is taken.
// Depends on chisq_pkg, chisq_in_if, chisq_out_if, chisq_hist and chisq_div.

module chi_square_uniformity_test import chisq_pkg::*; #(
  parameter int unsigned BINS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  chisq_in_if.sink         samp_i,
  chisq_out_if.source      res_o
);

  localparam int unsigned BCW   = $clog2(BINS + 1);
  localparam int unsigned NUM_W = SUMSQ_W + BCW;
  localparam int unsigned DIV_W = NUM_W + FRAC_W;
  localparam logic [BCW-1:0] BINS_V = BCW'(BINS);

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_UPD  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_LOAD = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   len_q;
  logic [LEN_W-1:0]   eff_len;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic [SUMSQ_W-1:0] sumsq_q, sumsq_d;
  logic [IDX_W-1:0]   blocks_q, blocks_d;
  logic [NUM_W-1:0]   num_q;
  logic [SQR_W-1:0]   n2_q;
  logic [NUM_W-1:0]   diff;
  logic [LEN_W:0]     cnt_next;
  logic [LEN_W:0]     sq_incr;
  logic               accept;
  logic               res_free;
  logic               res_load;
  logic               res_valid_q;
  logic [CHI_W-1:0]   res_chi_q;
  logic [IDX_W-1:0]   res_idx_q;
  hist_ctrl_t         hist_ctrl;
  hist_stat_t         hist_stat;
  div_stat_t          div_stat;
  logic [DIV_W-1:0]   quotient;

  // block length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // zero counts as one, anything above the maximum saturates
  always_comb begin
    priority if (len_q == '0) begin
      eff_len = LEN_MIN;
    end else if (len_q > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = len_q;
    end
  end

  // handshake
  assign samp_i.ready = (state_q == ST_IDLE);
  assign accept       = samp_i.valid && samp_i.ready;
  assign res_free     = !res_valid_q || res_o.ready;
  assign res_load     = (state_q == ST_DONE) && res_free;
  assign cnt_next     = {1'b0, cnt_q} + (LEN_W + 1)'(1);

  // histogram control
  assign hist_ctrl.lookup = accept;
  assign hist_ctrl.update = (state_q == ST_UPD);
  assign hist_ctrl.clear  = (state_q == ST_CLR);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:  if (hist_stat.clear_last) state_d = ST_IDLE;
      ST_IDLE: if (accept) state_d = ST_UPD;
      ST_UPD: begin
        state_d = (cnt_next >= {1'b0, eff_len}) ? ST_MUL : ST_IDLE;
      end
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (div_stat.done) state_d = ST_DONE;
      ST_DONE: if (res_free) state_d = ST_CLR;
      default: state_d = ST_CLR;
    endcase
  end

  // block counters
  always_comb begin
    cnt_d    = cnt_q;
    sumsq_d  = sumsq_q;
    blocks_d = blocks_q;
    if (state_q == ST_UPD) begin
      cnt_d   = cnt_next[LEN_W-1:0];
      sumsq_d = sumsq_q + SUMSQ_W'(sq_incr);
    end else if (res_load) begin
      cnt_d    = '0;
      sumsq_d  = '0;
      blocks_d = blocks_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      cnt_q    <= '0;
      sumsq_q  <= '0;
      blocks_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sumsq_q  <= sumsq_d;
      blocks_q <= blocks_d;
    end
  end

  // BINS * sumsq and n^2, each registered
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      num_q <= NUM_W'(sumsq_q) * NUM_W'(BINS_V);
      n2_q  <= SQR_W'(cnt_q) * SQR_W'(cnt_q);
    end
  end

  // clamped numerator, scaled by 256 on its way into the divider
  assign diff = (num_q >= NUM_W'(n2_q)) ? (num_q - NUM_W'(n2_q)) : '0;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_chi_q <= quotient[CHI_W-1:0];
      res_idx_q <= blocks_q;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.chi_square  = res_chi_q;
  assign res_o.block_index = res_idx_q;

  chisq_hist #(
    .BINS (BINS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hist_ctrl),
    .sample_i  (samp_i.sample),
    .stat_o    (hist_stat),
    .sq_incr_o (sq_incr)
  );

  chisq_div #(
    .DW (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_LOAD),
    .dividend_i ({diff, FRAC_W'(0)}),
    .divisor_i  (cnt_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

`ifndef ASSERT_OFF
  // an accepted sample is always followed by its update
  a_accept_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_UPD)
    else $error("sample accepted without histogram update");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide wait");

  // the sample count before an update never reaches the maximum block length
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> cnt_q < LEN_MAX)
    else $error("sample count ran past the block length");

  // a loaded result carries the index of the block just finished
  a_res_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> res_valid_q && res_idx_q == $past(blocks_q) &&
                 blocks_q == $past(blocks_q) + IDX_W'(1))
    else $error("result index does not match the finished block");
`endif

endmodule

/* dv/chisq_stat_checker.sv */
// chisq_stat_checker: watches the sample and result channels of the chi-square block,
// keeps its own histogram, predicts every block statistic and compares each result
// depends on chisq_pkg, chisq_in_if and chisq_out_if
`timescale 1ns / 1ps

module chisq_stat_checker import chisq_pkg::*; #(
  parameter int unsigned BINS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  chisq_in_if              samp_i,
  chisq_out_if             res_i,
  input  logic             end_of_run_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o,
  output int unsigned      blocks_seen_o
);

  localparam int unsigned REPORT_MAX = 10;

  typedef struct {
    logic [CHI_W-1:0] chi_square;
    logic [IDX_W-1:0] block_index;
  } block_stat_t;

  // own copy of the block state and its length register
  logic [LEN_W-1:0]   blk_len = LEN_RESET;
  logic [LEN_W-1:0]   bin_count [BINS];
  logic [LEN_W-1:0]   fill    = '0;
  logic [SUMSQ_W-1:0] sumsq   = '0;
  logic [IDX_W-1:0]   blk_num = '0;

  // statistics of finished blocks not yet seen on the result channel
  block_stat_t stat_q [$];

  int unsigned err_cnt     = 0;
  int unsigned pend_cnt    = 0;
  int unsigned blocks_seen = 0;
  bit          closed      = 1'b0;

  assign errors_o      = err_cnt;
  assign pending_o     = pend_cnt;
  assign blocks_seen_o = blocks_seen;

  function automatic void note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) begin
      $display("%0t ns  mismatch: %s", $time, msg);
    end
  endfunction

  // zero means one, anything above the maximum saturates
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    if (len == '0) return LEN_MIN;
    if (len > LEN_MAX) return LEN_MAX;
    return len;
  endfunction

  function automatic void clear_hist();
    foreach (bin_count[i]) bin_count[i] = '0;
    fill  = '0;
    sumsq = '0;
  endfunction

  // bin the sample, update the sum of squares, close the block when full
  function automatic void tally_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned     bin;
    longint unsigned n;
    longint unsigned num;
    block_stat_t     st;
    bin = (32'(s) * BINS) >> SAMPLE_W;
    if (bin >= BINS) bin = BINS - 1;
    sumsq          += 2 * bin_count[bin] + 1;
    bin_count[bin] += 1'b1;
    fill           += 1'b1;
    if (fill < clamp_len(blk_len)) return;
    // (BINS*sumsq - n^2) * 256 / n, truncated
    n   = fill;
    num = 64'(BINS) * sumsq;
    num = (num >= n * n) ? num - n * n : 64'd0;
    st.chi_square  = CHI_W'((num << FRAC_W) / n);
    st.block_index = blk_num;
    stat_q.push_back(st);
    blk_num++;
    clear_hist();
  endfunction

  function automatic void check_result(input logic [CHI_W-1:0] chi,
                                       input logic [IDX_W-1:0] idx);
    block_stat_t want;
    if (stat_q.size() == 0) begin
      note_mismatch($sformatf("result with no block pending: chi_square %0d block_index %0d",
                              chi, idx));
      return;
    end
    want = stat_q.pop_front();
    blocks_seen++;
    if (chi !== want.chi_square) begin
      note_mismatch($sformatf("block %0d chi_square expected %0d got %0d",
                              want.block_index, want.chi_square, chi));
    end
    if (idx !== want.block_index) begin
      note_mismatch($sformatf("block_index expected %0d got %0d", want.block_index, idx));
    end
  endfunction

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_len = LEN_RESET;
      blk_num = '0;
      clear_hist();
      stat_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        check_result(res_i.chi_square, res_i.block_index);
      end
      if (cfg_we_i) begin
        blk_len = cfg_wdata_i;
      end
      if (samp_i.valid && samp_i.ready) begin
        tally_sample(samp_i.sample);
      end
      // statistics still owed at the end are failures
      if (end_of_run_i && !closed) begin
        closed = 1'b1;
        if (stat_q.size() != 0) begin
          err_cnt += stat_q.size();
          $display("%0t ns  %0d block results never arrived", $time, stat_q.size());
        end
      end
    end
    pend_cnt = stat_q.size();
  end

endmodule

/* dv/tb_chi_square_uniformity_test.sv */
// tb_chi_square_uniformity_test: drives samples and block length writes into the
// chi-square block with random stalls on both channels; chisq_stat_checker judges results
// depends on chisq_pkg, chisq_in_if, chisq_out_if, the block and chisq_stat_checker
`timescale 1ns / 1ps

module tb_chi_square_uniformity_test;
  import chisq_pkg::*;

  localparam int unsigned BINS           = 128;
  localparam int          CLK_HALF       = 6;
  localparam int unsigned RESET_CYCLES   = 11;
  // divide, then a clearing pass over every bin, with margin
  localparam int unsigned SETTLE_CYCLES  = 3 + 41 + 8 + BINS + 120;
  localparam int unsigned HOLD_CYCLES    = 900;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned DRAIN_LIMIT    = 50_000;
  localparam int unsigned TIMEOUT_CYCLES = 1_500_000;

  typedef enum int {MIX_FLAT, MIX_CLUSTER, MIX_ONE_BIN, MIX_EDGES} sample_mix_e;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we     = 1'b0;
  logic [LEN_W-1:0] cfg_wdata  = '0;
  logic             end_of_run = 1'b0;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned blocks_seen;

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 48;
  int unsigned hold_reqs     = 0;
  int unsigned samples_sent  = 0;
  int unsigned cfg_writes    = 0;

  chisq_in_if  samp_if ();
  chisq_out_if res_if ();

  chi_square_uniformity_test #(.BINS(BINS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .samp_i      (samp_if),
    .res_o       (res_if)
  );

  chisq_stat_checker #(.BINS(BINS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .samp_i        (samp_if),
    .res_i         (res_if),
    .end_of_run_i  (end_of_run),
    .errors_o      (fail_cnt),
    .pending_o     (pending),
    .blocks_seen_o (blocks_seen)
  );

  // clock
  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // result ready: random stalls, plus a long hold-off on request
  initial begin : ready_drive
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left    = 0;
    holds_seen   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("watchdog expired with %0d block results outstanding", pending);
    $display("chi_square_uniformity_test regression: fail");
    $finish;
  end

  // one sample request, with random gaps before it
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      samp_if.valid  = 1'b0;
      samp_if.sample = SAMPLE_W'($urandom);
      @(negedge clk_i);
    end
    samp_if.valid  = 1'b1;
    samp_if.sample = value;
    do @(posedge clk_i); while (!samp_if.ready);
    @(negedge clk_i);
    samples_sent++;
  endtask

  // sender pauses until every block statistic has come back
  task automatic drain_results();
    samp_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // register write only once the block has gone quiet
  task automatic write_block_len(input logic [LEN_W-1:0] len);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = len;
    @(negedge clk_i);
    cfg_we = 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_mix_e mix,
                                                      input int unsigned home_bin);
    int unsigned span;
    int unsigned bin;
    span = (1 << SAMPLE_W) / BINS;
    case (mix)
      MIX_FLAT: begin
        return SAMPLE_W'($urandom);
      end
      MIX_CLUSTER: begin
        bin = (home_bin + $urandom_range(3)) % BINS;
        return SAMPLE_W'(bin * span + $urandom_range(span - 1));
      end
      MIX_ONE_BIN: begin
        return SAMPLE_W'(home_bin * span + $urandom_range(span - 1));
      end
      default: begin
        // first or last code of a bin, the full-scale ends among them
        bin = $urandom_range(BINS - 1);
        return SAMPLE_W'(bin * span + ($urandom_range(1) ? span - 1 : 0));
      end
    endcase
  endfunction

  // a run of samples sharing one content pattern
  task automatic send_group(input int unsigned count);
    sample_mix_e mix;
    int unsigned home;
    int unsigned r;
    r    = $urandom_range(9);
    mix  = (r < 5) ? MIX_FLAT : (r < 7) ? MIX_CLUSTER : (r < 8) ? MIX_ONE_BIN : MIX_EDGES;
    home = $urandom_range(BINS - 1);
    repeat (count) send_sample(pick_sample(mix, home));
  endtask

  // mostly short blocks, sometimes a long setting that gets cut mid-block
  task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                           input bit with_hold);
    int unsigned      start_cnt;
    int unsigned      r;
    logic [LEN_W-1:0] len;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start_cnt     = samples_sent;
    if (with_hold) begin
      // one-sample blocks against a stalled receiver back the block up
      write_block_len(LEN_MIN);
      hold_reqs++;
      send_group(24);
    end
    while (samples_sent - start_cnt < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 10) begin
        // long or saturating length, then lowered to at most 12 mid-block
        write_block_len(LEN_W'($urandom_range(int'(LEN_MAX) * 2 - 1, 96)));
        send_group($urandom_range(12, 1));
        write_block_len(LEN_W'($urandom_range(12)));
        send_group($urandom_range(8, 1));
      end else begin
        if (r < 16)      len = '0;
        else if (r < 24) len = LEN_MIN;
        else if (r < 80) len = LEN_W'($urandom_range(16, 2));
        else             len = LEN_W'($urandom_range(48, 17));
        write_block_len(len);
        // whole blocks, sometimes a few left over into the next setting
        send_group(((len == '0) ? 1 : len) * $urandom_range(3, 1) + $urandom_range(2));
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    samp_if.valid  = 1'b0;
    samp_if.sample = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // a few samples at the reset length, then length zero ends that block
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h01FF);
    write_block_len('0);
    send_sample(16'h0200);
    // one-sample blocks
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    // whole block in one bin
    write_block_len(17'd4);
    repeat (4) send_sample(16'h8000);
    // above the maximum saturates, then the maximum, then cut to two
    write_block_len({LEN_W{1'b1}});
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h0001);
    write_block_len(LEN_MAX);
    send_sample(16'hFE00);
    send_sample(16'h81FF);
    write_block_len(17'd2);
    send_sample(16'h3C3C);

    // random phases: sender light and receiver heavy, the reverse, then none
    run_phase(12, 48, 1'b1);
    run_phase(48, 12, 1'b0);
    run_phase(0, 0, 1'b0);

    // wait for the last statistics, then let the block go quiet
    samp_if.valid = 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending != 0; i++) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    end_of_run = 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);

    $display("covered %0d samples, %0d block length writes, %0d block statistics checked",
             samples_sent, cfg_writes, blocks_seen);
    $display("lengths zero to saturating, mid-block cuts, a long result hold-off");
    if (fail_cnt == 0) begin
      $display("chi_square_uniformity_test regression: pass");
    end else begin
      $display("chi_square_uniformity_test regression: fail");
    end
    $finish;
  end

endmodule

/* chi_square_uniformity_test.f */
sv/chisq_pkg.sv
sv/chisq_in_if.sv
sv/chisq_out_if.sv
sv/chisq_hist.sv
sv/chisq_div.sv
sv/chi_square_uniformity_test.sv
dv/chisq_stat_checker.sv
dv/tb_chi_square_uniformity_test.sv
